>>> rtl/core/erpp_pkg.sv
// ----------------------------------------------------------------------------
// erpp_pkg
// Shared types, sizes and codes for the e-paper row pixel packer.
// ----------------------------------------------------------------------------
package erpp_pkg;

   localparam int ROW_PIXELS  = 2048;
   localparam int MAIN_BYTES  = 1024;
   localparam int PLANE_BYTES = 256;

   localparam int MAIN_AW  = $clog2(MAIN_BYTES);
   localparam int PLANE_AW = $clog2(PLANE_BYTES);

   localparam int PIX_W   = 11;
   localparam int BIDX_W  = 10;
   localparam int USED_W  = 11;
   localparam int FMT_W   = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 11;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_MONO  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_GREY2 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_3C    = 3'd2;
   localparam logic [FMT_W-1:0] FMT_4C    = 3'd3;
   localparam logic [FMT_W-1:0] FMT_7C    = 3'd4;

   // request types
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_PACK  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // three-colour classes
   localparam logic [7:0] CLS_BLACK = 8'd1;
   localparam logic [7:0] CLS_RED   = 8'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_PIXEL_FORMAT = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_USED_BYTES   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_FILL_1BPP    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_FILL_2BPP    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_FILL_4C      = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_FILL_4BPP    = 3'd5;

   localparam logic [USED_W-1:0] USED_RST = 11'd1024;
   localparam logic [7:0] FILL_1BPP_RST = 8'd255;
   localparam logic [7:0] FILL_2BPP_RST = 8'd255;
   localparam logic [7:0] FILL_4C_RST   = 8'd85;
   localparam logic [7:0] FILL_4BPP_RST = 8'd17;

   localparam logic [7:0] PAIR_MASK = 8'h03;
   localparam logic [7:0] NIB_HI    = 8'hF0;
   localparam logic [7:0] NIB_LO    = 8'h0F;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [PIX_W-1:0]  pixel_index;
      logic [7:0]        pixel_value;
      logic [BIDX_W-1:0] byte_index;
      logic              plane;
   } req_type_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [FMT_W-1:0]  pixel_format;
      logic [USED_W-1:0] used_bytes;
      logic [7:0]        white_fill_1bpp;
      logic [7:0]        white_fill_2bpp;
      logic [7:0]        white_fill_4c;
      logic [7:0]        white_fill_4bpp;
   } cfg_type;

   typedef struct packed {
      logic                main_re;
      logic [MAIN_AW-1:0]  main_raddr;
      logic                plane_re;
      logic [PLANE_AW-1:0] plane_raddr;
      logic                main_we;
      logic [MAIN_AW-1:0]  main_waddr;
      logic [7:0]          main_wdata;
      logic                plane_we;
      logic [PLANE_AW-1:0] plane_waddr;
      logic [7:0]          plane_wdata;
   } mem_cmd_type;

endpackage

>>> rtl/core/erpp_csr.sv
// ----------------------------------------------------------------------------
// erpp_csr
// Configuration registers of the row pixel packer.
// ----------------------------------------------------------------------------
module erpp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [erpp_pkg::CSR_AW-1:0]  csr_index,
   input  logic [erpp_pkg::CSR_DW-1:0]  csr_wdata,
   output erpp_pkg::cfg_type            cfg
);

   erpp_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            erpp_pkg::CSR_PIXEL_FORMAT: cfg_in.pixel_format    = csr_wdata[erpp_pkg::FMT_W-1:0];
            erpp_pkg::CSR_USED_BYTES:   cfg_in.used_bytes      = csr_wdata[erpp_pkg::USED_W-1:0];
            erpp_pkg::CSR_FILL_1BPP:    cfg_in.white_fill_1bpp = csr_wdata[7:0];
            erpp_pkg::CSR_FILL_2BPP:    cfg_in.white_fill_2bpp = csr_wdata[7:0];
            erpp_pkg::CSR_FILL_4C:      cfg_in.white_fill_4c   = csr_wdata[7:0];
            erpp_pkg::CSR_FILL_4BPP:    cfg_in.white_fill_4bpp = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format    <= erpp_pkg::FMT_MONO;
         cfg_ff.used_bytes      <= erpp_pkg::USED_RST;
         cfg_ff.white_fill_1bpp <= erpp_pkg::FILL_1BPP_RST;
         cfg_ff.white_fill_2bpp <= erpp_pkg::FILL_2BPP_RST;
         cfg_ff.white_fill_4c   <= erpp_pkg::FILL_4C_RST;
         cfg_ff.white_fill_4bpp <= erpp_pkg::FILL_4BPP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/erpp_mem.sv
// ----------------------------------------------------------------------------
// erpp_mem
// Main row store and colour plane store, registered reads.
// ----------------------------------------------------------------------------
module erpp_mem (
   input  logic                  clock,
   input  erpp_pkg::mem_cmd_type cmd,
   output logic [7:0]            main_rdata,
   output logic [7:0]            plane_rdata
);

   logic [7:0] main_row_store     [erpp_pkg::MAIN_BYTES];
   logic [7:0] colour_plane_store [erpp_pkg::PLANE_BYTES];
   logic [7:0] main_rd_ff;
   logic [7:0] plane_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.main_we) begin
         main_row_store[cmd.main_waddr] <= cmd.main_wdata;
      end
      if (cmd.main_re) begin
         main_rd_ff <= main_row_store[cmd.main_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.plane_we) begin
         colour_plane_store[cmd.plane_waddr] <= cmd.plane_wdata;
      end
      if (cmd.plane_re) begin
         plane_rd_ff <= colour_plane_store[cmd.plane_raddr];
      end
   end

   assign main_rdata  = main_rd_ff;
   assign plane_rdata = plane_rd_ff;

endmodule

>>> rtl/core/erpp_seq.sv
// ----------------------------------------------------------------------------
// erpp_seq
// Request sequencer: address and bound checks, read-modify-write of one
// byte, clear sweep and the response register.
// ----------------------------------------------------------------------------
module erpp_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  erpp_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  erpp_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output erpp_pkg::rsp_type      rsp_data,
   output erpp_pkg::mem_cmd_type  cmd,
   input  logic [7:0]             main_rdata,
   input  logic [7:0]             plane_rdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MOD   = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [erpp_pkg::USED_W-1:0]    cnt_ff, cnt_in;
   logic [1:0]                     op_ff, op_in;
   logic [2:0]                     xlo_ff, xlo_in;
   logic [7:0]                     val_ff, val_in;
   logic                           psel_ff, psel_in;
   logic                           oor_ff, oor_in;
   logic [erpp_pkg::MAIN_AW-1:0]   addr_ff, addr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   erpp_pkg::rsp_type              rsp_ff, rsp_in;

   logic [erpp_pkg::USED_W-1:0]    main_bound;
   logic [erpp_pkg::USED_W-1:0]    plane_bound;
   logic [erpp_pkg::PIX_W-1:0]     pix_idx;
   logic                           pack_oor;
   logic                           read_oor;
   logic                           is_3c;
   logic                           out_free;
   logic [7:0]                     fill;
   logic [7:0]                     new_main;
   logic [7:0]                     new_plane;
   logic [2:0]                     sh;
   logic [7:0]                     pmask;
   logic [1:0]                     code;
   logic [7:0]                     bmask;
   logic                           blk;
   logic                           col;

   assign main_bound  = (32'(cfg.used_bytes) < erpp_pkg::MAIN_BYTES)
                        ? cfg.used_bytes : erpp_pkg::USED_W'(erpp_pkg::MAIN_BYTES);
   assign plane_bound = (32'(cfg.used_bytes) < erpp_pkg::PLANE_BYTES)
                        ? cfg.used_bytes : erpp_pkg::USED_W'(erpp_pkg::PLANE_BYTES);
   assign is_3c       = (cfg.pixel_format == erpp_pkg::FMT_3C);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cfg.pixel_format)
         erpp_pkg::FMT_GREY2: fill = cfg.white_fill_2bpp;
         erpp_pkg::FMT_4C:    fill = cfg.white_fill_4c;
         erpp_pkg::FMT_7C:    fill = cfg.white_fill_4bpp;
         default:             fill = cfg.white_fill_1bpp;
      endcase
   end

   // byte index and bound check of an incoming transaction
   always_comb begin
      unique case (cfg.pixel_format)
         erpp_pkg::FMT_GREY2, erpp_pkg::FMT_4C:
            pix_idx = erpp_pkg::PIX_W'(req_data.pixel_index >> 2);
         erpp_pkg::FMT_7C:
            pix_idx = erpp_pkg::PIX_W'(req_data.pixel_index >> 1);
         default:
            pix_idx = erpp_pkg::PIX_W'(req_data.pixel_index >> 3);
      endcase
      pack_oor = (32'(req_data.pixel_index) >= erpp_pkg::ROW_PIXELS)
                 || (32'(pix_idx) >= 32'(main_bound))
                 || (is_3c && (32'(pix_idx) >= 32'(plane_bound)));
      if (req_data.plane) begin
         read_oor = 32'(req_data.byte_index) >= 32'(plane_bound);
      end else begin
         read_oor = 32'(req_data.byte_index) >= 32'(main_bound);
      end
   end

   // byte modify
   always_comb begin
      sh        = {~xlo_ff[1:0], 1'b0};
      pmask     = erpp_pkg::PAIR_MASK << sh;
      code      = (cfg.pixel_format == erpp_pkg::FMT_GREY2) ? val_ff[7:6] : val_ff[1:0];
      bmask     = 8'd1 << (~xlo_ff);
      blk       = (val_ff != erpp_pkg::CLS_BLACK);
      col       = (val_ff == erpp_pkg::CLS_BLACK) || (val_ff != erpp_pkg::CLS_RED);
      new_plane = col ? (plane_rdata | bmask) : (plane_rdata & ~bmask);
      unique case (cfg.pixel_format)
         erpp_pkg::FMT_GREY2, erpp_pkg::FMT_4C:
            new_main = (main_rdata & ~pmask) | (8'(code) << sh);
         erpp_pkg::FMT_7C:
            new_main = xlo_ff[0] ? ((main_rdata & erpp_pkg::NIB_HI) | {4'd0, val_ff[3:0]})
                                 : ((main_rdata & erpp_pkg::NIB_LO) | {val_ff[3:0], 4'd0});
         erpp_pkg::FMT_3C:
            new_main = blk ? (main_rdata | bmask) : (main_rdata & ~bmask);
         default:
            new_main = (val_ff == 8'd0) ? (main_rdata | bmask) : (main_rdata & ~bmask);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      xlo_in       = xlo_ff;
      val_in       = val_ff;
      psel_in      = psel_ff;
      oor_in       = oor_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.main_raddr  = (req_data.req_type == erpp_pkg::REQ_READ)
                              ? req_data.byte_index[erpp_pkg::MAIN_AW-1:0]
                              : pix_idx[erpp_pkg::MAIN_AW-1:0];
            cmd.plane_raddr = (req_data.req_type == erpp_pkg::REQ_READ)
                              ? req_data.byte_index[erpp_pkg::PLANE_AW-1:0]
                              : pix_idx[erpp_pkg::PLANE_AW-1:0];
            if (req_valid) begin
               cmd.main_re  = 1'b1;
               cmd.plane_re = 1'b1;
               op_in        = req_data.req_type;
               xlo_in       = req_data.pixel_index[2:0];
               val_in       = req_data.pixel_value;
               psel_in      = req_data.plane;
               addr_in      = pix_idx[erpp_pkg::MAIN_AW-1:0];
               unique case (req_data.req_type)
                  erpp_pkg::REQ_PACK: oor_in = pack_oor;
                  erpp_pkg::REQ_READ: oor_in = read_oor;
                  default:            oor_in = 1'b0;
               endcase
               if (req_data.req_type == erpp_pkg::REQ_CLEAR) begin
                  cnt_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (out_free) begin
               cmd.main_we      = (op_ff == erpp_pkg::REQ_PACK) && !oor_ff;
               cmd.plane_we     = cmd.main_we && is_3c;
               cmd.main_waddr   = addr_ff;
               cmd.plane_waddr  = addr_ff[erpp_pkg::PLANE_AW-1:0];
               cmd.main_wdata   = new_main;
               cmd.plane_wdata  = new_plane;
               rsp_valid_in     = 1'b1;
               rsp_in.out_of_range = oor_ff;
               if ((op_ff == erpp_pkg::REQ_READ) && !oor_ff) begin
                  rsp_in.read_data = psel_ff ? plane_rdata : main_rdata;
               end else begin
                  rsp_in.read_data = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.main_waddr  = cnt_ff[erpp_pkg::MAIN_AW-1:0];
            cmd.plane_waddr = cnt_ff[erpp_pkg::PLANE_AW-1:0];
            cmd.main_wdata  = fill;
            cmd.plane_wdata = fill;
            if (cnt_ff < main_bound) begin
               cmd.main_we  = 1'b1;
               cmd.plane_we = is_3c && (cnt_ff < plane_bound);
               cnt_in       = cnt_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      xlo_ff  <= xlo_in;
      val_ff  <= val_in;
      psel_ff <= psel_in;
      oor_ff  <= oor_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/epaper_row_pixel_packer_top.sv
// ----------------------------------------------------------------------------
// epaper_row_pixel_packer_top
// Packed pixel line buffer for one e-paper row.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request channel (valid/ready), payload req_data: clear row,
//            pack one pixel or read one byte.
//   rsp_*  : one response transaction per request: read byte and
//            out-of-range flag, held in an output register.
//   csr_*  : register write port, used only while the block is idle.
// Timing:
//   Pack and read first do the registered memory read, then the
//   modify, write-back and response.
//   A clear writes min(used_bytes, 1024) bytes, one byte per cycle
//   through the single write port of each store.
//   The next request is taken as soon as the sequencer is idle, even with
//   a response still waiting; a stalled receiver then holds the following
//   transaction in its last step until the output register frees.
// Reset:
//   Registers return to their defaults, no response pending. Store contents
//   stay undefined until written by a clear or a pack.
// ----------------------------------------------------------------------------
module epaper_row_pixel_packer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  erpp_pkg::req_type_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output erpp_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [erpp_pkg::CSR_AW-1:0]  csr_index,
   input  logic [erpp_pkg::CSR_DW-1:0]  csr_wdata
);

   erpp_pkg::cfg_type     cfg;
   erpp_pkg::mem_cmd_type cmd;
   logic [7:0]            main_rdata;
   logic [7:0]            plane_rdata;

   erpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   erpp_mem u_mem (
      .clock       (clock),
      .cmd         (cmd),
      .main_rdata  (main_rdata),
      .plane_rdata (plane_rdata)
   );

   erpp_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .main_rdata  (main_rdata),
      .plane_rdata (plane_rdata)
   );

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous transaction in flight");

   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.main_we && cmd.main_re))
      else $error("main store read and write in the same cycle");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.read_data == 8'd0))
      else $error("out-of-range response carries data");

   a_plane_with_main: assert property (@(posedge clock) disable iff (reset)
      cmd.plane_we |-> cmd.main_we)
      else $error("colour plane written without main store");

endmodule

>>> tb/tb_epaper_row_pixel_packer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epaper_row_pixel_packer_top
// Self-checking bench for the packed e-paper row buffer. A short directed
// pass covers clears, packs and reads in the mono, three-colour and grey
// formats, zero and unit row lengths, unknown formats and classes, and
// colour plane reads. It is followed by randomized phases that each
// program a new register setting, clear the row and run a mix of packs,
// reads, clears and no-op requests. A scoreboard keeps its own copy of
// both stores and predicts every response; bursty request traffic and a
// patterned response stall are applied throughout.
// ----------------------------------------------------------------------------
module tb_epaper_row_pixel_packer_top;

   localparam logic [1:0]                 REQ_NONE  = 2'd3;
   localparam logic [7:0]                 CLS_WHITE = 8'd0;
   localparam logic [7:0]                 CLS_OTHER = 8'd3;
   localparam logic [erpp_pkg::FMT_W-1:0] FMT_SPARE = 3'd7;

   localparam int RAND_PHASES     = 12;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int TAIL_CYCLES     = 8;

   class row_buffer_scoreboard;
      erpp_pkg::cfg_type cfg;
      logic [7:0]        main_row [erpp_pkg::MAIN_BYTES];
      logic [7:0]        color_row [erpp_pkg::PLANE_BYTES];
      erpp_pkg::rsp_type expected_rsp [$];
      int unsigned       errors;

      function new();
         cfg.pixel_format    = erpp_pkg::FMT_MONO;
         cfg.used_bytes      = erpp_pkg::USED_RST;
         cfg.white_fill_1bpp = erpp_pkg::FILL_1BPP_RST;
         cfg.white_fill_2bpp = erpp_pkg::FILL_2BPP_RST;
         cfg.white_fill_4c   = erpp_pkg::FILL_4C_RST;
         cfg.white_fill_4bpp = erpp_pkg::FILL_4BPP_RST;
         errors = 0;
      endfunction

      function void write_reg(logic [erpp_pkg::CSR_AW-1:0] idx,
                              logic [erpp_pkg::CSR_DW-1:0] data);
         case (idx)
            erpp_pkg::CSR_PIXEL_FORMAT: cfg.pixel_format = data[erpp_pkg::FMT_W-1:0];
            erpp_pkg::CSR_USED_BYTES:   cfg.used_bytes   = data[erpp_pkg::USED_W-1:0];
            erpp_pkg::CSR_FILL_1BPP:    cfg.white_fill_1bpp = data[7:0];
            erpp_pkg::CSR_FILL_2BPP:    cfg.white_fill_2bpp = data[7:0];
            erpp_pkg::CSR_FILL_4C:      cfg.white_fill_4c   = data[7:0];
            erpp_pkg::CSR_FILL_4BPP:    cfg.white_fill_4bpp = data[7:0];
            default: ;
         endcase
      endfunction

      function int main_limit();
         return (int'(cfg.used_bytes) < erpp_pkg::MAIN_BYTES) ? int'(cfg.used_bytes)
                                                              : erpp_pkg::MAIN_BYTES;
      endfunction

      function int plane_limit();
         return (int'(cfg.used_bytes) < erpp_pkg::PLANE_BYTES) ? int'(cfg.used_bytes)
                                                               : erpp_pkg::PLANE_BYTES;
      endfunction

      function erpp_pkg::rsp_type predict_response(erpp_pkg::req_type_type r);
         erpp_pkg::rsp_type          rsp;
         int                         idx;
         int                         bound;
         int                         sh;
         logic [7:0]                 b;
         logic [7:0]                 fill;
         logic [2:0]                 pos;
         logic [erpp_pkg::PIX_W-1:0] x;
         logic [7:0]                 val;
         rsp = '0;
         x   = r.pixel_index;
         val = r.pixel_value;
         case (r.req_type)
            erpp_pkg::REQ_CLEAR: begin
               case (cfg.pixel_format)
                  erpp_pkg::FMT_GREY2: fill = cfg.white_fill_2bpp;
                  erpp_pkg::FMT_4C:    fill = cfg.white_fill_4c;
                  erpp_pkg::FMT_7C:    fill = cfg.white_fill_4bpp;
                  default:             fill = cfg.white_fill_1bpp;
               endcase
               for (int i = 0; i < main_limit(); i++) main_row[i] = fill;
               if (cfg.pixel_format == erpp_pkg::FMT_3C)
                  for (int i = 0; i < plane_limit(); i++) color_row[i] = fill;
            end
            erpp_pkg::REQ_PACK: begin
               bound = main_limit();
               case (cfg.pixel_format)
                  erpp_pkg::FMT_GREY2, erpp_pkg::FMT_4C: idx = int'(x >> 2);
                  erpp_pkg::FMT_7C:                      idx = int'(x >> 1);
                  erpp_pkg::FMT_3C: begin
                     idx   = int'(x >> 3);
                     bound = plane_limit();
                  end
                  default:                               idx = int'(x >> 3);
               endcase
               if (int'(x) >= erpp_pkg::ROW_PIXELS || idx >= bound) begin
                  rsp.out_of_range = 1'b1;
               end else begin
                  b   = main_row[idx];
                  sh  = 2 * (3 - int'(x[1:0]));
                  pos = 3'd7 - x[2:0];
                  case (cfg.pixel_format)
                     erpp_pkg::FMT_GREY2: b[sh +: 2] = val[7:6];
                     erpp_pkg::FMT_4C:    b[sh +: 2] = val[1:0];
                     erpp_pkg::FMT_7C: begin
                        if (x[0]) b[3:0] = val[3:0];
                        else      b[7:4] = val[3:0];
                     end
                     erpp_pkg::FMT_3C: begin
                        b[pos] = (val != erpp_pkg::CLS_BLACK);
                        color_row[idx][pos] = (val != erpp_pkg::CLS_RED);
                     end
                     default:   b[pos] = (val == 8'd0);
                  endcase
                  main_row[idx] = b;
               end
            end
            erpp_pkg::REQ_READ: begin
               if (!r.plane) begin
                  if (int'(r.byte_index) < main_limit())
                     rsp.read_data = main_row[r.byte_index];
                  else
                     rsp.out_of_range = 1'b1;
               end else begin
                  if (int'(r.byte_index) < plane_limit())
                     rsp.read_data = color_row[r.byte_index];
                  else
                     rsp.out_of_range = 1'b1;
               end
            end
            default: ;
         endcase
         return rsp;
      endfunction

      function void note_request(erpp_pkg::req_type_type r);
         expected_rsp.push_back(predict_response(r));
      endfunction

      function void check_response(erpp_pkg::rsp_type got);
         erpp_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t  unexpected transaction: read_data %02h out_of_range %0b",
                     $time, got.read_data, got.out_of_range);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.read_data !== want.read_data) begin
            $display("%0t  read_data: expected %02h, actual %02h",
                     $time, want.read_data, got.read_data);
            errors++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $display("%0t  out_of_range: expected %0b, actual %0b",
                     $time, want.out_of_range, got.out_of_range);
            errors++;
         end
      endfunction
   endclass

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   erpp_pkg::req_type_type        req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   erpp_pkg::rsp_type             rsp_data;
   logic                          csr_we    = 1'b0;
   logic [erpp_pkg::CSR_AW-1:0]   csr_index = '0;
   logic [erpp_pkg::CSR_DW-1:0]   csr_wdata = '0;

   row_buffer_scoreboard sb = new();
   int                   burst_left     = 0;
   int                   last_pack_byte = 0;
   int                   quiet_cycles   = 0;
   logic [31:0]          rx_cycle       = '0;

   epaper_row_pixel_packer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // response side stall pattern, mode chosen by bits 10:9 of the cycle counter
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[10:9])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_ready <= (rx_cycle % 7) != 0;
         default: rsp_ready <= rx_cycle[4:0] >= 5'd20;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t  no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** epaper_row_pixel_packer_top: FAILED **");
      $finish;
   end

   task automatic send_request(erpp_pkg::req_type_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [erpp_pkg::CSR_AW-1:0] idx,
                            logic [erpp_pkg::CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_setting(erpp_pkg::cfg_type c);
      write_csr(erpp_pkg::CSR_PIXEL_FORMAT, erpp_pkg::CSR_DW'(c.pixel_format));
      write_csr(erpp_pkg::CSR_USED_BYTES,   erpp_pkg::CSR_DW'(c.used_bytes));
      write_csr(erpp_pkg::CSR_FILL_1BPP,    erpp_pkg::CSR_DW'(c.white_fill_1bpp));
      write_csr(erpp_pkg::CSR_FILL_2BPP,    erpp_pkg::CSR_DW'(c.white_fill_2bpp));
      write_csr(erpp_pkg::CSR_FILL_4C,      erpp_pkg::CSR_DW'(c.white_fill_4c));
      write_csr(erpp_pkg::CSR_FILL_4BPP,    erpp_pkg::CSR_DW'(c.white_fill_4bpp));
      csr_we <= 1'b0;
   endtask

   function automatic erpp_pkg::req_type_type make_req(logic [1:0] kind, int x, int val,
                                                       int b, bit pl);
      erpp_pkg::req_type_type r;
      r.req_type    = kind;
      r.pixel_index = x[erpp_pkg::PIX_W-1:0];
      r.pixel_value = val[7:0];
      r.byte_index  = b[erpp_pkg::BIDX_W-1:0];
      r.plane       = pl;
      return r;
   endfunction

   // Packs mostly land inside the used row; reads often revisit the last packed byte.
   function automatic erpp_pkg::req_type_type random_request();
      erpp_pkg::req_type_type r;
      int unsigned            roll;
      int                     ppb;
      int                     span;
      int                     bound;
      r    = $urandom;
      roll = $urandom_range(0, 99);
      case (sb.cfg.pixel_format)
         erpp_pkg::FMT_GREY2, erpp_pkg::FMT_4C: ppb = 4;
         erpp_pkg::FMT_7C:                      ppb = 2;
         default:                               ppb = 8;
      endcase
      span = (sb.cfg.pixel_format == erpp_pkg::FMT_3C) ? sb.plane_limit() : sb.main_limit();
      if (roll < 2) begin
         r.req_type = erpp_pkg::REQ_CLEAR;
      end else if (roll < 5) begin
         r.req_type = REQ_NONE;
      end else if (roll < 60) begin
         r.req_type = erpp_pkg::REQ_PACK;
         if (span != 0 && $urandom_range(0, 3) != 0)
            r.pixel_index = erpp_pkg::PIX_W'($urandom_range(0,
               ((span * ppb > erpp_pkg::ROW_PIXELS) ? erpp_pkg::ROW_PIXELS
                                                    : span * ppb) - 1));
         if (sb.cfg.pixel_format == erpp_pkg::FMT_3C && $urandom_range(0, 3) != 0)
            r.pixel_value = 8'($urandom_range(0, 3));
         last_pack_byte = int'(r.pixel_index) / ppb;
      end else begin
         r.req_type = erpp_pkg::REQ_READ;
         bound = r.plane ? sb.plane_limit() : sb.main_limit();
         if ($urandom_range(0, 1))
            r.byte_index = erpp_pkg::BIDX_W'(last_pack_byte);
         else if (bound != 0 && $urandom_range(0, 4) != 0)
            r.byte_index = erpp_pkg::BIDX_W'($urandom_range(0, bound - 1));
      end
      return r;
   endfunction

   initial begin
      erpp_pkg::cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Mono at reset settings. The clear here and the three-colour clear with
      // the longest row below leave both stores fully written from then on.
      send_request(make_req(erpp_pkg::REQ_CLEAR, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 2047, 255, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 9, 1, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 255, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 1023, 0));
      send_request(make_req(REQ_NONE, 2047, 255, 1023, 1));

      drain();
      c = sb.cfg;
      c.pixel_format    = erpp_pkg::FMT_3C;
      c.used_bytes      = 11'd2047;
      c.white_fill_1bpp = 8'h00;
      apply_setting(c);
      send_request(make_req(erpp_pkg::REQ_CLEAR, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 0, int'(CLS_WHITE), 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 1, int'(erpp_pkg::CLS_BLACK), 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 2, int'(erpp_pkg::CLS_RED), 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 3, int'(CLS_OTHER), 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 1));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 256, 1));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 1023, 0));

      drain();
      c.pixel_format = erpp_pkg::FMT_GREY2;
      c.used_bytes   = '0;
      apply_setting(c);
      send_request(make_req(erpp_pkg::REQ_CLEAR, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 0, 255, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 1));

      drain();
      c.pixel_format    = FMT_SPARE;
      c.used_bytes      = 11'd1;
      c.white_fill_1bpp = 8'hA5;
      apply_setting(c);
      send_request(make_req(erpp_pkg::REQ_CLEAR, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 7, 1, 0, 0));
      send_request(make_req(erpp_pkg::REQ_PACK, 8, 1, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 0));
      send_request(make_req(erpp_pkg::REQ_READ, 0, 0, 0, 1));

      for (int p = 0; p < RAND_PHASES; p++) begin
         drain();
         c.pixel_format = (p < 8) ? p[erpp_pkg::FMT_W-1:0]
                                  : erpp_pkg::FMT_W'($urandom_range(0, 4));
         case (p % 6)
            0:       c.used_bytes = 11'd1024;
            1:       c.used_bytes = erpp_pkg::USED_W'($urandom_range(1, 16));
            2:       c.used_bytes = 11'd2047;
            3:       c.used_bytes = 11'd256;
            4:       c.used_bytes = erpp_pkg::USED_W'($urandom_range(17, 300));
            default: c.used_bytes = 11'd1;
         endcase
         if (p < 2) begin
            c.white_fill_1bpp = (p == 0) ? 8'h00 : 8'hFF;
            c.white_fill_2bpp = c.white_fill_1bpp;
            c.white_fill_4c   = c.white_fill_1bpp;
            c.white_fill_4bpp = c.white_fill_1bpp;
         end else begin
            c.white_fill_1bpp = 8'($urandom);
            c.white_fill_2bpp = 8'($urandom);
            c.white_fill_4c   = 8'($urandom);
            c.white_fill_4bpp = 8'($urandom);
         end
         apply_setting(c);
         send_request(make_req(erpp_pkg::REQ_CLEAR, $urandom, $urandom, $urandom,
                               1'($urandom_range(0, 1))));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("** epaper_row_pixel_packer_top: PASSED **");
      else
         $display("** epaper_row_pixel_packer_top: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/erpp_pkg.sv
rtl/core/erpp_csr.sv
rtl/core/erpp_mem.sv
rtl/core/erpp_seq.sv
rtl/core/epaper_row_pixel_packer_top.sv
tb/tb_epaper_row_pixel_packer_top.sv
